// ===== src/clre_pkg.sv =====
// ----------------------------------------------------------------------------
// clre_pkg
// shared widths, constants, tables and types of the coefficient level rate
// estimator
// ----------------------------------------------------------------------------
package clre_pkg;

  localparam int LevelW    = 16;
  localparam int StateW    = 7;
  localparam int RiceW     = 3;
  localparam int CountW    = 5;
  localparam int LimitW    = 5;
  localparam int RateW     = 22;
  localparam int CostW     = 18;
  localparam int FlagCostW = CostW + 1;
  localparam int BitsW     = 7;
  localparam int OneBitSh  = 15;

  localparam int DefQueueDepth = 2;

  localparam int RemainReduction = 3;
  localparam logic [RiceW-1:0] MaxRice = 3'd4;

  // configuration port
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic RegGreater1Limit = 1'b0;
  localparam logic RegGreater2Limit = 1'b1;
  localparam logic [LimitW-1:0] Greater1LimitRst = 5'd8;
  localparam logic [LimitW-1:0] Greater2LimitRst = 5'd1;

  localparam logic [6:0] RiceSpan [5] = '{7'd7, 7'd14, 7'd26, 7'd46, 7'd78};
  localparam logic [3:0] RicePrefixMax [5] = '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4};

  localparam logic [CostW-1:0] BinCost [128] = '{
    18'h08000, 18'h08000, 18'h076da, 18'h089a0, 18'h06e92, 18'h09340, 18'h0670a, 18'h09cdf,
    18'h06029, 18'h0a67f, 18'h059dd, 18'h0b01f, 18'h05413, 18'h0b9bf, 18'h04ebf, 18'h0c35f,
    18'h049d3, 18'h0ccff, 18'h04546, 18'h0d69e, 18'h0410d, 18'h0e03e, 18'h03d22, 18'h0e9de,
    18'h0397d, 18'h0f37e, 18'h03619, 18'h0fd1e, 18'h032ee, 18'h106be, 18'h02ffa, 18'h1105d,
    18'h02d37, 18'h119fd, 18'h02aa2, 18'h1239d, 18'h02836, 18'h12d3d, 18'h025f2, 18'h136dd,
    18'h023d1, 18'h1407c, 18'h021d2, 18'h14a1c, 18'h01ff2, 18'h153bc, 18'h01e2f, 18'h15d5c,
    18'h01c87, 18'h166fc, 18'h01af7, 18'h1709b, 18'h0197f, 18'h17a3b, 18'h0181d, 18'h183db,
    18'h016d0, 18'h18d7b, 18'h01595, 18'h1971b, 18'h0146c, 18'h1a0bb, 18'h01354, 18'h1aa5a,
    18'h0124c, 18'h1b3fa, 18'h01153, 18'h1bd9a, 18'h01067, 18'h1c73a, 18'h00f89, 18'h1d0da,
    18'h00eb7, 18'h1da79, 18'h00df0, 18'h1e419, 18'h00d34, 18'h1edb9, 18'h00c82, 18'h1f759,
    18'h00bda, 18'h200f9, 18'h00b3c, 18'h20a99, 18'h00aa5, 18'h21438, 18'h00a17, 18'h21dd8,
    18'h00990, 18'h22778, 18'h00911, 18'h23118, 18'h00898, 18'h23ab8, 18'h00826, 18'h24458,
    18'h007ba, 18'h24df7, 18'h00753, 18'h25797, 18'h006f2, 18'h26137, 18'h00696, 18'h26ad7,
    18'h0063f, 18'h27477, 18'h005ed, 18'h27e17, 18'h0059f, 18'h287b6, 18'h00554, 18'h29156,
    18'h0050e, 18'h29af6, 18'h004cc, 18'h2a497, 18'h0048d, 18'h2ae35, 18'h00451, 18'h2b7d6,
    18'h00418, 18'h2c176, 18'h003e2, 18'h2cb15, 18'h003af, 18'h2d4b5, 18'h0037f, 18'h2de55
  };

  // classified item between front and back
  typedef struct packed {
    logic                 mode;
    logic                 rem_en;
    logic [LevelW-1:0]    sym;
    logic [RiceW-1:0]     rice;
    logic [FlagCostW-1:0] flag_cost;
  } entry_t;

endpackage

// ===== src/clre_in_if.sv =====
// ----------------------------------------------------------------------------
// clre_in_if
// query channel of the rate estimator: valid/ready plus one query item
// ----------------------------------------------------------------------------
interface clre_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [clre_pkg::LevelW-1:0]      coeff_level;
  logic [clre_pkg::StateW-1:0]      greater1_ctx_state;
  logic [clre_pkg::StateW-1:0]      greater2_ctx_state;
  logic [clre_pkg::RiceW-1:0]       rice_param;
  logic [clre_pkg::CountW-1:0]      greater1_count;
  logic [clre_pkg::CountW-1:0]      greater2_count;

  modport source (
    output valid, mode, coeff_level, greater1_ctx_state, greater2_ctx_state,
    output rice_param, greater1_count, greater2_count,
    input  ready
  );
  modport sink (
    input  valid, mode, coeff_level, greater1_ctx_state, greater2_ctx_state,
    input  rice_param, greater1_count, greater2_count,
    output ready
  );
endinterface

// ===== src/clre_out_if.sv =====
// ----------------------------------------------------------------------------
// clre_out_if
// result channel of the rate estimator: valid/ready plus one rate item
// ----------------------------------------------------------------------------
interface clre_out_if;
  logic                       valid;
  logic                       ready;
  logic [clre_pkg::RateW-1:0] rate;

  modport source (output valid, rate, input ready);
  modport sink (input valid, rate, output ready);
endinterface

// ===== src/clre_front.sv =====
// ----------------------------------------------------------------------------
// clre_front
// accepts query items, derives base level and flag bins, prices the flag bins
// and hands a classified item to the queue
// ----------------------------------------------------------------------------
module clre_front (
  clre_in_if.sink                        in_i,
  input  logic [clre_pkg::LimitW-1:0]    g1_limit_i,
  input  logic [clre_pkg::LimitW-1:0]    g2_limit_i,
  input  logic                           full_i,
  output logic                           push_o,
  output clre_pkg::entry_t               entry_o
);

  logic                          g1_coded;
  logic                          g2_coded;
  logic [1:0]                    base;
  logic                          at_base;
  logic                          lvl_one;
  logic                          lvl_two;
  logic                          bin1;
  logic                          bin2;
  logic                          use1;
  logic                          use2;
  logic [clre_pkg::StateW-1:0]   idx1;
  logic [clre_pkg::StateW-1:0]   idx2;
  logic [clre_pkg::CostW-1:0]    cost1;
  logic [clre_pkg::CostW-1:0]    cost2;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    g1_coded = in_i.greater1_count < g1_limit_i;
    g2_coded = in_i.greater2_count < g2_limit_i;
    base     = g1_coded ? (g2_coded ? 2'd3 : 2'd2) : 2'd1;
    at_base  = in_i.coeff_level >= clre_pkg::LevelW'(base);
    lvl_one  = in_i.coeff_level == clre_pkg::LevelW'(1);
    lvl_two  = in_i.coeff_level == clre_pkg::LevelW'(2);

    // bin values and which flags are priced
    bin1 = at_base || lvl_two;
    bin2 = at_base;
    use1 = at_base ? g1_coded : (lvl_one || lvl_two);
    use2 = at_base ? (g1_coded && g2_coded) : lvl_two;
    idx1 = in_i.greater1_ctx_state ^ clre_pkg::StateW'(bin1);
    idx2 = in_i.greater2_ctx_state ^ clre_pkg::StateW'(bin2);
    cost1 = use1 ? clre_pkg::BinCost[idx1] : '0;
    cost2 = use2 ? clre_pkg::BinCost[idx2] : '0;

    entry_o.mode      = in_i.mode;
    entry_o.rem_en    = at_base;
    entry_o.sym       = in_i.coeff_level - clre_pkg::LevelW'(base);
    entry_o.rice      = (in_i.rice_param > clre_pkg::MaxRice) ? clre_pkg::MaxRice
                                                              : in_i.rice_param;
    entry_o.flag_cost = clre_pkg::FlagCostW'(cost1) + clre_pkg::FlagCostW'(cost2);
  end

endmodule

// ===== src/clre_queue.sv =====
// ----------------------------------------------------------------------------
// clre_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module clre_queue #(
  parameter int Depth = clre_pkg::DefQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clre_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output clre_pkg::entry_t entry_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  clre_pkg::entry_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count missed a push");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("queue count missed a pop");
`endif

endmodule

// ===== src/clre_back.sv =====
// ----------------------------------------------------------------------------
// clre_back
// prices the bypass remainder of a classified item, adds flag cost and base,
// and holds the result in the output register
// ----------------------------------------------------------------------------
module clre_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clre_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  clre_out_if.source       out_o
);

  logic                          out_valid_q, out_valid_d;
  logic [clre_pkg::RateW-1:0]    rate_q, rate_d;

  logic [6:0]                    span;
  logic [3:0]                    pmax;
  logic [5:0]                    thr;
  logic                          esc;
  logic [clre_pkg::LevelW-1:0]   enc_in;
  logic [3:0]                    msb;
  logic [clre_pkg::LevelW-1:0]   quot;
  logic [3:0]                    quot_cap;
  logic [clre_pkg::BitsW-1:0]    rem_bits;
  logic [clre_pkg::BitsW-1:0]    total_bits;

  always_comb begin
    span = clre_pkg::RiceSpan[entry_i.rice];
    pmax = clre_pkg::RicePrefixMax[entry_i.rice];
    thr  = 6'(clre_pkg::RemainReduction) << entry_i.rice;
    esc  = entry_i.mode ? (entry_i.sym >= clre_pkg::LevelW'(thr))
                        : (entry_i.sym >  clre_pkg::LevelW'(span));

    // shared leading-one search for both escape codes
    enc_in = entry_i.mode ? entry_i.sym - (clre_pkg::LevelW'(2) << entry_i.rice)
                          : entry_i.sym - clre_pkg::LevelW'(span);
    msb = '0;
    for (int i = 0; i < clre_pkg::LevelW; i++) begin
      if (enc_in[i]) begin
        msb = 4'(i);
      end
    end

    quot     = (entry_i.sym >> entry_i.rice) + clre_pkg::LevelW'(1);
    quot_cap = (quot > clre_pkg::LevelW'(pmax)) ? pmax : quot[3:0];

    if (!esc) begin
      rem_bits = clre_pkg::BitsW'(quot_cap) + clre_pkg::BitsW'(entry_i.rice);
    end else if (!entry_i.mode) begin
      rem_bits = clre_pkg::BitsW'({msb, 1'b1}) + clre_pkg::BitsW'(pmax)
               + clre_pkg::BitsW'(entry_i.rice);
    end else begin
      rem_bits = clre_pkg::BitsW'(4) + clre_pkg::BitsW'({msb, 1'b0})
               - clre_pkg::BitsW'(entry_i.rice);
    end

    total_bits = (entry_i.rem_en ? rem_bits : '0) + clre_pkg::BitsW'(entry_i.mode);
  end

  assign pop_o = !empty_i && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    rate_d      = rate_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      rate_d      = (clre_pkg::RateW'(total_bits) << clre_pkg::OneBitSh)
                  + clre_pkg::RateW'(entry_i.flag_cost);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.rate  = rate_q;

`ifndef NO_ASSERTIONS
  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped item did not reach output register");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !pop_o)
    else $error("pending result overwritten");
  a_base_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && entry_i.mode |=> rate_q >= clre_pkg::RateW'(1 << clre_pkg::OneBitSh))
    else $error("remainder-bin result lost its base bit");
`endif

endmodule

// ===== src/coeff_level_rate_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// coeff_level_rate_estimator_unit
// estimates the CABAC cost of one absolute coefficient level in 1/32768 bit
// ----------------------------------------------------------------------------
// channel   direction  handshake      payload
// in_i      sink       valid / ready  mode, coeff_level, ctx states, rice, counts
// out_o     source     valid / ready  rate
// apb       slave      psel/penable   greater1 / greater2 flag limits
//
// one item per cycle sustained while out_o is not stalled; an item passes the queue, then the output register
// front prices flag bins, back prices the remainder in one leading-one search
// a stalled output holds QueueDepth items in the queue plus one in the output
// register before input ready drops; ready returns in the cycle after a pop
// reset clears queue pointers, output valid and restores the flag limits
// ----------------------------------------------------------------------------
module coeff_level_rate_estimator_unit #(
  parameter int QueueDepth = clre_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  clre_in_if.sink                       in_i,
  clre_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clre_pkg::AddrW-1:0]    paddr,
  input  logic [clre_pkg::DataW-1:0]    pwdata,
  output logic [clre_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [clre_pkg::LimitW-1:0] g1_limit_q, g1_limit_d;
  logic [clre_pkg::LimitW-1:0] g2_limit_q, g2_limit_d;
  logic                        wr_en;
  logic                        push;
  logic                        pop;
  logic                        full;
  logic                        empty;
  clre_pkg::entry_t            push_entry;
  clre_pkg::entry_t            head_entry;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    g1_limit_d = g1_limit_q;
    g2_limit_d = g2_limit_q;
    if (wr_en) begin
      case (paddr[2])
        clre_pkg::RegGreater1Limit: g1_limit_d = pwdata[clre_pkg::LimitW-1:0];
        clre_pkg::RegGreater2Limit: g2_limit_d = pwdata[clre_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      clre_pkg::RegGreater1Limit: prdata = clre_pkg::DataW'(g1_limit_q);
      clre_pkg::RegGreater2Limit: prdata = clre_pkg::DataW'(g2_limit_q);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_limit_q <= clre_pkg::Greater1LimitRst;
      g2_limit_q <= clre_pkg::Greater2LimitRst;
    end else begin
      g1_limit_q <= g1_limit_d;
      g2_limit_q <= g2_limit_d;
    end
  end

  clre_front u_front (
    .in_i       (in_i),
    .g1_limit_i (g1_limit_q),
    .g2_limit_i (g2_limit_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  clre_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  clre_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
